[hw/rtl/sodrf_pkg.sv]
package sodrf_pkg;

  // Field widths
  localparam int unsigned TempW  = 11;
  localparam int unsigned HumW   = 10;
  localparam int unsigned GasW   = 12;
  localparam int unsigned RawW   = 12;
  localparam int unsigned SoilW  = 7;
  localparam int unsigned IdleW  = 32;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DiffW  = 13;

  // Stream payload widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  // Command codes
  localparam logic [CmdW-1:0] CmdTick   = 2'd0;
  localparam logic [CmdW-1:0] CmdSample = 2'd1;
  localparam logic [CmdW-1:0] CmdSend   = 2'd2;

  // Register indexes
  localparam logic [CfgAddrW-1:0] RegTempThr = 3'd0;
  localparam logic [CfgAddrW-1:0] RegHumThr  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegGasThr  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegSoilThr = 3'd3;
  localparam logic [CfgAddrW-1:0] RegIdleLim = 3'd4;

  // Register reset values
  localparam logic [TempW-1:0] TempThrReset = 11'd5;
  localparam logic [HumW-1:0]  HumThrReset  = 10'd20;
  localparam logic [GasW-1:0]  GasThrReset  = 12'd50;
  localparam logic [SoilW-1:0] SoilThrReset = 7'd5;
  localparam logic [IdleW-1:0] IdleLimReset = 32'd300000;

  // Soil conversion constants
  localparam logic [RawW-1:0] RawMax = 12'd4095;

  typedef struct packed {
    logic [TempW-1:0] temp_threshold;
    logic [HumW-1:0]  hum_threshold;
    logic [GasW-1:0]  gas_threshold;
    logic [SoilW-1:0] soil_threshold;
    logic [IdleW-1:0] idle_limit;
  } cfg_t;

  // One registered input transaction, soil already in percent
  typedef struct packed {
    logic [CmdW-1:0]         command;
    logic signed [TempW-1:0] temp_tenths;
    logic [HumW-1:0]         hum_tenths;
    logic [GasW-1:0]         gas_raw;
    logic [SoilW-1:0]        soil_pct;
    logic                    reading_valid;
    logic                    sent_ok;
  } item_t;

  typedef struct packed {
    logic signed [TempW-1:0] report_temp;
    logic [HumW-1:0]         report_hum;
    logic [GasW-1:0]         report_gas;
    logic [SoilW-1:0]        report_soil_pct;
    logic                    heartbeat;
  } report_t;

  // Absolute difference of two signed values that fit in DiffW-1 bits.
  function automatic logic [DiffW-1:0] abs_diff(logic signed [DiffW-1:0] a,
                                                logic signed [DiffW-1:0] b);
    logic signed [DiffW-1:0] d;
    d = a - b;
    return d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
  endfunction

endpackage

[hw/rtl/sodrf_soil_pct.sv]
// Converts a raw soil reading to floor((4095 - raw) * 100 / 4095).
module sodrf_soil_pct (
  input  logic [sodrf_pkg::RawW-1:0]  raw_i,
  output logic [sodrf_pkg::SoilW-1:0] pct_o
);

  logic [sodrf_pkg::RawW-1:0]   wet;
  logic [18:0]                  prod;
  logic [sodrf_pkg::SoilW-1:0]  quo0;
  logic [12:0]                  rem;

  // Times 100 as shift-adds.
  assign wet  = sodrf_pkg::RawMax - raw_i;
  assign prod = ({7'd0, wet} << 6) + ({7'd0, wet} << 5) + ({7'd0, wet} << 2);

  // Divide by 4096 first, then correct by one: the remainder against 4095 is
  // the low twelve bits plus the first quotient, which stays below 2 * 4095.
  assign quo0 = prod[18:12];
  assign rem  = {1'b0, prod[11:0]} + {6'd0, quo0};
  assign pct_o = quo0 + ((rem >= 13'd4095) ? 7'd1 : 7'd0);

endmodule

[hw/rtl/sodrf_cfg_regs.sv]
// Threshold and idle limit registers behind the plain write port.
module sodrf_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sodrf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [sodrf_pkg::CfgDataW-1:0] cfg_wdata_i,
  output sodrf_pkg::cfg_t                cfg_o
);

  sodrf_pkg::cfg_t cfg_q;

  // Writes to indexes past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_threshold <= sodrf_pkg::TempThrReset;
      cfg_q.hum_threshold  <= sodrf_pkg::HumThrReset;
      cfg_q.gas_threshold  <= sodrf_pkg::GasThrReset;
      cfg_q.soil_threshold <= sodrf_pkg::SoilThrReset;
      cfg_q.idle_limit     <= sodrf_pkg::IdleLimReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sodrf_pkg::RegTempThr: cfg_q.temp_threshold <= cfg_wdata_i[sodrf_pkg::TempW-1:0];
        sodrf_pkg::RegHumThr:  cfg_q.hum_threshold  <= cfg_wdata_i[sodrf_pkg::HumW-1:0];
        sodrf_pkg::RegGasThr:  cfg_q.gas_threshold  <= cfg_wdata_i[sodrf_pkg::GasW-1:0];
        sodrf_pkg::RegSoilThr: cfg_q.soil_threshold <= cfg_wdata_i[sodrf_pkg::SoilW-1:0];
        sodrf_pkg::RegIdleLim: cfg_q.idle_limit     <= cfg_wdata_i[sodrf_pkg::IdleW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/sodrf_core.sv]
// Reference, pending sample and idle counter, and the report decision for
// the item held in the input register.
module sodrf_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sodrf_pkg::cfg_t     cfg_i,
  input  logic                item_valid_i,
  input  sodrf_pkg::item_t    item_i,
  input  logic                advance_i,
  output logic                report_o,
  output sodrf_pkg::report_t  result_o
);

  logic signed [sodrf_pkg::TempW-1:0] ref_temp_q, pend_temp_q;
  logic [sodrf_pkg::HumW-1:0]         ref_hum_q, pend_hum_q;
  logic [sodrf_pkg::GasW-1:0]         ref_gas_q, pend_gas_q;
  logic [sodrf_pkg::SoilW-1:0]        ref_soil_q, pend_soil_q;
  logic                               have_ref_q, pend_valid_q;
  logic [sodrf_pkg::IdleW-1:0]        idle_q;

  logic is_tick, is_sample, is_send, commit;
  logic heart, trig_temp, trig_hum, trig_gas, trig_soil;

  assign is_tick   = item_valid_i && (item_i.command == sodrf_pkg::CmdTick);
  assign is_sample = item_valid_i && (item_i.command == sodrf_pkg::CmdSample)
                     && item_i.reading_valid;
  assign is_send   = item_valid_i && (item_i.command == sodrf_pkg::CmdSend);
  assign commit    = is_send && pend_valid_q && item_i.sent_ok;

  // Change detection against the committed reference.
  assign heart = idle_q >= cfg_i.idle_limit;
  assign trig_temp = sodrf_pkg::abs_diff(
                       sodrf_pkg::DiffW'(item_i.temp_tenths),
                       sodrf_pkg::DiffW'(ref_temp_q))
                     >= {2'd0, cfg_i.temp_threshold};
  assign trig_hum  = sodrf_pkg::abs_diff(
                       {3'd0, item_i.hum_tenths}, {3'd0, ref_hum_q})
                     >= {3'd0, cfg_i.hum_threshold};
  assign trig_gas  = sodrf_pkg::abs_diff(
                       {1'b0, item_i.gas_raw}, {1'b0, ref_gas_q})
                     >= {1'b0, cfg_i.gas_threshold};
  assign trig_soil = sodrf_pkg::abs_diff(
                       {6'd0, item_i.soil_pct}, {6'd0, ref_soil_q})
                     >= {6'd0, cfg_i.soil_threshold};

  assign report_o = is_sample &&
                    (!have_ref_q || heart || trig_temp || trig_hum || trig_gas || trig_soil);

  assign result_o.report_temp     = item_i.temp_tenths;
  assign result_o.report_hum      = item_i.hum_tenths;
  assign result_o.report_gas      = item_i.gas_raw;
  assign result_o.report_soil_pct = item_i.soil_pct;
  assign result_o.heartbeat       = heart;

  // Control state: idle count, reference flag, pending flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q       <= '0;
      have_ref_q   <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (advance_i) begin
      if (is_tick && (idle_q != '1)) begin
        idle_q <= idle_q + 1'b1;
      end
      if (commit) begin
        idle_q     <= '0;
        have_ref_q <= 1'b1;
      end
      if (is_send) begin
        pend_valid_q <= 1'b0;
      end else if (report_o) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  // Reference and pending sample values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_temp_q  <= '0;
      ref_hum_q   <= '0;
      ref_gas_q   <= '0;
      ref_soil_q  <= '0;
      pend_temp_q <= '0;
      pend_hum_q  <= '0;
      pend_gas_q  <= '0;
      pend_soil_q <= '0;
    end else if (advance_i) begin
      if (commit) begin
        ref_temp_q <= pend_temp_q;
        ref_hum_q  <= pend_hum_q;
        ref_gas_q  <= pend_gas_q;
        ref_soil_q <= pend_soil_q;
      end
      if (report_o) begin
        pend_temp_q <= item_i.temp_tenths;
        pend_hum_q  <= item_i.hum_tenths;
        pend_gas_q  <= item_i.gas_raw;
        pend_soil_q <= item_i.soil_pct;
      end
    end
  end

endmodule

[hw/rtl/send_on_delta_report_filter.sv]
// Send-on-delta report filter with heartbeat.
// Input stream: tuser carries the command (tick, sample, send outcome), tdata
// the readings and the two flags. Each accepted sample with good readings is
// compared with the last committed reference; it produces one report on the
// output stream when any reading moved by at least its threshold, when no
// reference exists, or when the idle tick count has reached the idle limit
// (tuser then flags a heartbeat). A successful send outcome commits the last
// report as the new reference and clears the idle count.
// Thresholds and the idle limit are written through the cfg port; the user
// must write them only while idle, which the block itself does not enforce.
// A report passes through the input register, then the result register,
// before it is valid on the output. Throughput is one transaction per cycle
// while no report is held up by a stalled output; ticks and send outcomes
// never wait on the output. Reset returns the configuration registers to
// their defaults, clears the valid flags and clears the reference.
// When the receiver stalls, a report waits in the result register and the
// input register keeps one more transaction; a further report then holds
// s_axis_tready low until the output drains.
module send_on_delta_report_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [sodrf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [sodrf_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: temp_tenths[10:0], hum_tenths[20:11], gas_raw[32:21],
  //        soil_raw[44:33], reading_valid[45], sent_ok[46], zero[47]
  input  logic [sodrf_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: command[1:0]
  input  logic [sodrf_pkg::CmdW-1:0]     s_axis_tuser,
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: report_temp[10:0], report_hum[20:11], report_gas[32:21],
  //        report_soil_pct[39:33]
  output logic [sodrf_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: heartbeat[0]
  output logic                           m_axis_tuser
);

  sodrf_pkg::cfg_t    cfg;
  sodrf_pkg::item_t   item_d, item_q;
  sodrf_pkg::report_t result, out_q;
  logic               in_valid_q, out_valid_q;
  logic               report, out_free, in_adv, s_acc;
  logic [sodrf_pkg::SoilW-1:0] soil_pct;

  sodrf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Soil percent is worked out ahead of the input register.
  sodrf_soil_pct u_soil (
    .raw_i (s_axis_tdata[44:33]),
    .pct_o (soil_pct)
  );

  assign item_d.command       = s_axis_tuser;
  assign item_d.temp_tenths   = s_axis_tdata[10:0];
  assign item_d.hum_tenths    = s_axis_tdata[20:11];
  assign item_d.gas_raw       = s_axis_tdata[32:21];
  assign item_d.soil_pct      = soil_pct;
  assign item_d.reading_valid = s_axis_tdata[45];
  assign item_d.sent_ok       = s_axis_tdata[46];

  sodrf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (in_valid_q),
    .item_i       (item_q),
    .advance_i    (in_adv),
    .report_o     (report),
    .result_o     (result)
  );

  // Handshake between the input register and the result register.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_adv        = in_valid_q && (!report || out_free);
  assign s_axis_tready = !in_valid_q || in_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      item_q <= item_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_adv && report;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && report) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.report_soil_pct, out_q.report_gas,
                          out_q.report_hum, out_q.report_temp};
  assign m_axis_tuser  = out_q.heartbeat;

  // A held transaction is never dropped.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_adv |=> in_valid_q)
    else $error("input transaction dropped while stalled");

  // A report cannot overwrite a stalled result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && report && out_valid_q && !m_axis_tready |-> !in_adv)
    else $error("report overwrote a stalled result");

  // Every report that leaves the input register shows up on the output.
  a_report_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv && report |=> m_axis_tvalid)
    else $error("report lost on its way to the output");

  // An empty input register always takes a transaction.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty input register");

endmodule
